// File: sv/b64d_pkg.sv
`timescale 1ns / 1ps

package b64d_pkg;

   localparam int QueueDepthDefault = 4;

   localparam logic [7:0] CharUpperA = 8'h41;
   localparam logic [7:0] CharUpperZ = 8'h5a;
   localparam logic [7:0] CharLowerA = 8'h61;
   localparam logic [7:0] CharLowerZ = 8'h7a;
   localparam logic [7:0] CharDigit0 = 8'h30;
   localparam logic [7:0] CharDigit9 = 8'h39;
   localparam logic [7:0] CharPlus   = 8'h2b;
   localparam logic [7:0] CharSlash  = 8'h2f;

   localparam logic [5:0] LowerBase  = 6'd26;
   localparam logic [5:0] DigitBase  = 6'd52;
   localparam logic [5:0] PlusValue  = 6'd62;
   localparam logic [5:0] SlashValue = 6'd63;

   // up to three bytes for the back end, first byte in the top bits
   typedef struct packed {
      logic [23:0] bytes;
      logic [1:0]  last_idx;
      logic        has_byte;
      logic        text_end;
   } bundle_type;

   // bit 6: character is a base64 letter, bits 5:0: its value
   function automatic logic [6:0] sextet_of(input logic [7:0] c);
      logic [7:0] d;
      logic [6:0] res;
      res = 7'd0;
      d   = 8'd0;
      if (c >= CharUpperA && c <= CharUpperZ) begin
         d   = c - CharUpperA;
         res = {1'b1, d[5:0]};
      end else if (c >= CharLowerA && c <= CharLowerZ) begin
         d   = c - CharLowerA;
         res = {1'b1, d[5:0] + LowerBase};
      end else if (c >= CharDigit0 && c <= CharDigit9) begin
         d   = c - CharDigit0;
         res = {1'b1, d[5:0] + DigitBase};
      end else if (c == CharPlus) begin
         res = {1'b1, PlusValue};
      end else if (c == CharSlash) begin
         res = {1'b1, SlashValue};
      end
      return res;
   endfunction

endpackage

// File: sv/b64d_front.sv
`timescale 1ns / 1ps

module b64d_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [7:0]          req_tdata,
   input  logic                req_tuser,
   input  logic                req_tlast,
   input  logic                queue_full,
   output logic                push,
   output b64d_pkg::bundle_type bundle
);
   import b64d_pkg::*;

   logic [17:0] store_ff, store_in, store_new;
   logic [1:0]  count_ff, count_in, count_new;
   logic        stopped_ff, stopped_in, stopped_new;
   logic [6:0]  code;
   logic        take;
   logic        group_done;
   logic        accept;

   assign req_tready = !queue_full;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      code        = sextet_of(req_tdata);
      take        = req_tuser && !stopped_ff;
      group_done  = take && code[6] && (count_ff == 2'd3);
      store_new   = store_ff;
      count_new   = count_ff;
      stopped_new = stopped_ff;
      if (take) begin
         if (!code[6]) begin
            stopped_new = 1'b1;
         end else if (count_ff == 2'd3) begin
            store_new = 18'd0;
            count_new = 2'd0;
         end else begin
            store_new = {store_ff[11:0], code[5:0]};
            count_new = count_ff + 2'd1;
         end
      end

      bundle.bytes    = 24'd0;
      bundle.last_idx = 2'd0;
      bundle.has_byte = 1'b0;
      bundle.text_end = req_tlast;
      if (group_done) begin
         bundle.bytes    = {store_ff, code[5:0]};
         bundle.last_idx = 2'd2;
         bundle.has_byte = 1'b1;
      end else if (req_tlast) begin
         case (count_new)
            2'd2: begin
               bundle.bytes    = {store_new[11:4], 16'd0};
               bundle.has_byte = 1'b1;
            end
            2'd3: begin
               bundle.bytes    = {store_new[17:10], store_new[9:2], 8'd0};
               bundle.last_idx = 2'd1;
               bundle.has_byte = 1'b1;
            end
            default: begin
               bundle.has_byte = 1'b0;
            end
         endcase
      end

      push = accept && (group_done || req_tlast);

      // end of text returns everything to its reset values
      if (req_tlast) begin
         store_in   = 18'd0;
         count_in   = 2'd0;
         stopped_in = 1'b0;
      end else begin
         store_in   = store_new;
         count_in   = count_new;
         stopped_in = stopped_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         store_ff   <= 18'd0;
         count_ff   <= 2'd0;
         stopped_ff <= 1'b0;
      end else if (accept) begin
         store_ff   <= store_in;
         count_ff   <= count_in;
         stopped_ff <= stopped_in;
      end
   end

endmodule

// File: sv/b64d_queue.sv
`timescale 1ns / 1ps

module b64d_queue #(
   parameter int Depth = b64d_pkg::QueueDepthDefault
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  b64d_pkg::bundle_type push_data,
   input  logic                pop,
   output logic                full,
   output logic                empty,
   output b64d_pkg::bundle_type head
);
   import b64d_pkg::*;

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   bundle_type            slot_ff [Depth];
   logic [PtrW-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]       count_ff, count_in;
   logic                  do_push;
   logic                  do_pop;

   assign full    = (count_ff == CntW'(Depth));
   assign empty   = (count_ff == '0);
   assign head    = slot_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + PtrW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + PtrW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CntW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: sv/b64d_back.sv
`timescale 1ns / 1ps

module b64d_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                empty,
   input  b64d_pkg::bundle_type head,
   output logic                pop,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [7:0]          rsp_tdata,
   output logic [1:0]          rsp_tuser,
   output logic                rsp_tlast
);
   import b64d_pkg::*;

   logic [1:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   logic [7:0] data_ff, data_in;
   logic       present_ff, present_in;
   logic       last_ff, last_in;
   logic       end_ff, end_in;
   logic       load;
   logic       emit;
   logic       final_one;

   always_comb begin
      load      = !valid_ff || rsp_tready;
      emit      = load && !empty;
      final_one = (idx_ff == head.last_idx);
      pop       = emit && final_one;

      case (idx_ff)
         2'd0:    data_in = head.bytes[23:16];
         2'd1:    data_in = head.bytes[15:8];
         default: data_in = head.bytes[7:0];
      endcase
      valid_in   = !empty;
      present_in = head.has_byte;
      last_in    = final_one;
      end_in     = final_one && head.text_end;

      idx_in = idx_ff;
      if (emit) begin
         idx_in = final_one ? 2'd0 : idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= 2'd0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff <= idx_in;
         if (load) begin
            valid_ff <= valid_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         data_ff    <= data_in;
         present_ff <= present_in;
         last_ff    <= last_in;
         end_ff     <= end_in;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tuser  = {end_ff, present_ff};
   assign rsp_tlast  = last_ff;

endmodule

// File: sv/base64_text_decoder_top.sv
`timescale 1ns / 1ps

// Base64 text decoder, one character per transfer in, one byte per transfer out.
// Input channel req_: tdata is the character code, tuser is 1 when tdata holds
// a character, tlast marks the final transfer of the text.
// Result channel rsp_: tdata is a decoded byte, tuser[0] is 1 for a real byte
// and 0 for the empty end marker, tuser[1] flags the final result of the text,
// tlast flags the last result caused by one input transfer.
// Four letters give three bytes; '=' or any other character stops decoding
// until the end of the text, where a partial group of n letters gives n-1
// bytes, or an empty marker when no byte is due.
// Throughput: one input transfer per cycle while the bundle queue has room, and one
// result per cycle while the receiver is ready. A result passes through the bundle
// queue and then the output register; a full group leaves the output stage as three
// results in turn, and the bundle queue (QueueDepth entries) absorbs the difference.
// Reset clears the group state, empties the queue and clears the output valid flag.
// When rsp_tvalid is high and rsp_tready is low the output register holds; once the
// queue fills, req_tready drops until the receiver takes results again.
module base64_text_decoder_top #(
   parameter int QueueDepth = b64d_pkg::QueueDepthDefault
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] symbol
   input  logic       req_tuser,   // [0] symbol_present
   input  logic       req_tlast,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] data_byte
   output logic [1:0] rsp_tuser,   // [0] byte_present, [1] message_end
   output logic       rsp_tlast
);
   import b64d_pkg::*;

   bundle_type push_data;
   bundle_type head;
   logic       push;
   logic       pop;
   logic       full;
   logic       empty;

   b64d_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .queue_full (full),
      .push       (push),
      .bundle     (push_data)
   );

   b64d_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .full      (full),
      .empty     (empty),
      .head      (head)
   );

   b64d_back u_back (
      .clock      (clock),
      .reset      (reset),
      .empty      (empty),
      .head       (head),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// File: sv/b64d_checker.sv
`timescale 1ns / 1ps

module b64d_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic [1:0] rsp_tuser,
   input logic       rsp_tlast
);

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled result changed");

   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> rsp_tlast)
      else $error("message end without run end");

   a_marker_form: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tlast && rsp_tuser[1] && rsp_tdata == 8'd0)
      else $error("malformed end marker");

endmodule

bind base64_text_decoder_top b64d_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

// File: sim/base64_text_decoder_top_test.sv
`timescale 1ns / 1ps

module base64_text_decoder_top_test;

   typedef struct {
      logic [7:0] symbol;
      logic       present;
      logic       eot;
   } char_item_type;

   typedef struct {
      logic [7:0] data_byte;
      logic       byte_present;
      logic       run_last;
      logic       message_end;
   } decoded_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = 8'd0;
   logic       req_tuser = 1'b0;
   logic       req_tlast = 1'b0;
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;
   logic [1:0] rsp_tuser;
   logic       rsp_tlast;

   string      alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
   logic [6:0] sextet_tab [256];

   char_item_type pending_chars[$];
   decoded_type   expected_bytes[$];

   // decoder state as predicted
   logic [17:0] held_sextets = 18'd0;
   logic [1:0]  gathered = 2'd0;
   logic        halted = 1'b0;

   int errors = 0;
   int queued_items = 0;
   int total_chars = 0;
   int texts = 0;
   int sent_chars = 0;
   int seen_bytes = 0;
   int seen_markers = 0;
   int run_cycle = 0;
   logic holding;
   logic quiet;

   base64_text_decoder_top u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (reset) begin
         run_cycle <= 0;
      end else begin
         run_cycle <= run_cycle + 1;
      end
   end

   // long receiver hold-off early on, then a stretch with no idling on either side
   assign holding = (run_cycle >= 40) && (run_cycle < 190);
   assign quiet   = (run_cycle >= 260) && (run_cycle < 460);

   task automatic flag_mismatch(input string what);
      $display("MISMATCH at %0t: %s", $realtime, what);
      errors++;
   endtask

   task automatic push_decoded(input logic [7:0] b, input logic bp, input logic rl,
                               input logic me);
      decoded_type d;
      d.data_byte    = b;
      d.byte_present = bp;
      d.run_last     = rl;
      d.message_end  = me;
      expected_bytes.insert(expected_bytes.size(), d);
   endtask

   task automatic decode_char(input char_item_type it);
      logic [6:0]  sx;
      logic [23:0] word;
      logic [7:0]  got [3];
      int          n;
      int          k;
      n = 0;
      if (it.present && !halted) begin
         sx = sextet_tab[it.symbol];
         if (!sx[6]) begin
            halted = 1'b1;
         end else if (gathered == 2'd3) begin
            word   = {held_sextets, sx[5:0]};
            got[0] = word[23:16];
            got[1] = word[15:8];
            got[2] = word[7:0];
            n = 3;
            held_sextets = 18'd0;
            gathered     = 2'd0;
         end else begin
            held_sextets = {held_sextets[11:0], sx[5:0]};
            gathered     = gathered + 2'd1;
         end
      end
      if (it.eot) begin
         if (gathered == 2'd2) begin
            got[2'(n)] = held_sextets[11:4];
            n = n + 1;
         end else if (gathered == 2'd3) begin
            got[2'(n)]     = held_sextets[17:10];
            got[2'(n + 1)] = held_sextets[9:2];
            n = n + 2;
         end
         held_sextets = 18'd0;
         gathered     = 2'd0;
         halted       = 1'b0;
      end
      if (it.eot && n == 0) begin
         push_decoded(8'd0, 1'b0, 1'b1, 1'b1);
      end else begin
         for (k = 0; k < n; k++) begin
            push_decoded(got[2'(k)], 1'b1, k == n - 1, (k == n - 1) && it.eot);
         end
      end
   endtask

   task automatic push_char(input logic [7:0] sym, input logic present, input logic eot);
      char_item_type it;
      it.symbol  = sym;
      it.present = present;
      it.eot     = eot;
      pending_chars.insert(pending_chars.size(), it);
      if (present || eot) queued_items++;
      if (eot) texts++;
   endtask

   function automatic logic [7:0] letter(input int v);
      return alphabet[v];
   endfunction

   // driver: advance to the next pending item once the current transfer is taken
   always @(posedge clock) begin
      char_item_type it;
      char_item_type nx;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            it.symbol  = req_tdata;
            it.present = req_tuser;
            it.eot     = req_tlast;
            decode_char(it);
            sent_chars++;
         end
         if (!req_tvalid || req_tready) begin
            if (pending_chars.size() > 0 && (quiet || $urandom_range(0, 99) >= 24)) begin
               nx = pending_chars.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= nx.symbol;
               req_tuser  <= nx.present;
               req_tlast  <= nx.eot;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // monitor: check each result transfer against the oldest prediction
   always @(posedge clock) begin
      decoded_type d;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (rsp_tuser[0]) seen_bytes++;
            else seen_markers++;
            if (expected_bytes.size() == 0) begin
               flag_mismatch($sformatf("unpredicted result byte %02h user %b last %b",
                                       rsp_tdata, rsp_tuser, rsp_tlast));
            end else begin
               d = expected_bytes.pop_front();
               if (rsp_tdata !== d.data_byte)
                  flag_mismatch($sformatf("data_byte %02h, want %02h", rsp_tdata, d.data_byte));
               if (rsp_tuser[0] !== d.byte_present)
                  flag_mismatch($sformatf("byte_present %b, want %b", rsp_tuser[0],
                                          d.byte_present));
               if (rsp_tlast !== d.run_last)
                  flag_mismatch($sformatf("run_last %b, want %b", rsp_tlast, d.run_last));
               if (rsp_tuser[1] !== d.message_end)
                  flag_mismatch($sformatf("message_end %b, want %b", rsp_tuser[1],
                                          d.message_end));
            end
         end
         rsp_tready <= !holding && (quiet || $urandom_range(0, 99) >= 24);
      end
   end

   initial begin
      int i;
      int len;
      int pad;
      int r;
      char_item_type tail;

      for (i = 0; i < 256; i++) sextet_tab[8'(i)] = 7'd0;
      for (i = 0; i < 64; i++) sextet_tab[alphabet[i]] = {1'b1, i[5:0]};

      // full group ending the text
      push_char("T", 1'b1, 1'b0); push_char("W", 1'b1, 1'b0);
      push_char("F", 1'b1, 1'b0); push_char("u", 1'b1, 1'b1);
      // two letters, then an end-only transfer
      push_char("A", 1'b1, 1'b0); push_char("A", 1'b1, 1'b0); push_char(8'h00, 1'b0, 1'b1);
      // three letters, character and end together
      push_char("/", 1'b1, 1'b0); push_char("/", 1'b1, 1'b0); push_char("+", 1'b1, 1'b1);
      // one pending letter at the end, then an empty text
      push_char("z", 1'b1, 1'b1);
      push_char(8'hff, 1'b0, 1'b1);
      // stop on padding, absent character, letter after the stop
      push_char("0", 1'b1, 1'b0); push_char("9", 1'b1, 1'b0); push_char("=", 1'b1, 1'b0);
      push_char(8'hff, 1'b0, 1'b0); push_char("A", 1'b1, 1'b1);
      // stop on an invalid character
      push_char("Z", 1'b1, 1'b0); push_char("z", 1'b1, 1'b0);
      push_char(8'h00, 1'b1, 1'b0); push_char("a", 1'b1, 1'b1);
      // full group, then an invalid character that also ends the text
      push_char("/", 1'b1, 1'b0); push_char("+", 1'b1, 1'b0);
      push_char("/", 1'b1, 1'b0); push_char("+", 1'b1, 1'b0);
      push_char(8'hff, 1'b1, 1'b1);

      while (queued_items < 330) begin
         if ($urandom_range(0, 99) < 85) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 9);
            for (i = 0; i < len; i++) begin
               if ($urandom_range(0, 9) == 0)
                  push_char(8'($urandom_range(0, 255)), 1'b0, 1'b0);
               push_char(letter($urandom_range(0, 63)), 1'b1, 1'b0);
            end
            pad = 0;
            if ((len % 4) >= 2 && $urandom_range(0, 1)) begin
               pad = 4 - (len % 4);
               for (i = 0; i < pad; i++) push_char("=", 1'b1, 1'b0);
            end
            r = $urandom_range(0, 2);
            if (r == 0 && (len + pad) > 0) begin
               tail = pending_chars.pop_back();
               tail.eot = 1'b1;
               pending_chars.insert(pending_chars.size(), tail);
               texts++;
            end else if (r == 2) begin
               push_char(letter($urandom_range(0, 63)), 1'b1, 1'b1);
            end else begin
               push_char(8'($urandom_range(0, 255)), 1'b0, 1'b1);
            end
         end else begin
            len = $urandom_range(1, 12);
            for (i = 0; i < len; i++) begin
               if ($urandom_range(0, 3) == 0)
                  push_char(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b0);
               else
                  push_char(letter($urandom_range(0, 63)), 1'b1, 1'b0);
            end
            push_char(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
         end
      end
      total_chars = pending_chars.size();

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      while (sent_chars < total_chars || expected_bytes.size() > 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
      if (expected_bytes.size() != 0)
         flag_mismatch($sformatf("%0d predicted results never arrived", expected_bytes.size()));

      $display("Decoded %0d texts from %0d character transfers", texts, sent_chars);
      $display("Checked %0d bytes and %0d end markers", seen_bytes, seen_markers);
      if (errors == 0) begin
         $display("base64_text_decoder_top test passed");
      end else begin
         $display("base64_text_decoder_top test failed");
      end
      $finish;
   end

   initial begin
      #200_000;
      $display("Timed out with %0d results outstanding", expected_bytes.size());
      $display("base64_text_decoder_top test failed");
      $finish;
   end

endmodule
